// ----- src/dlf_pkg.sv -----
// ---------------------------------------------------------------------------
// dlf_pkg: shared types and constants for the dense layer
// Sizes, command and register codes, and the item passed front to back.
// ---------------------------------------------------------------------------
package dlf_pkg;

	localparam int IN_MAX      = 64;
	localparam int OUT_MAX     = 64;
	localparam int TABLE_DEPTH = 256;

	localparam int DATA_W = 16;
	localparam int ACC_W  = 40;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 8;
	localparam int NEU_W  = 6;
	localparam int CNT_W  = 7;
	localparam int TBL_AW = 8;
	localparam int W_AW   = ROW_W + NEU_W;
	localparam int Q_FRAC = 12;

	// configuration register indexes
	localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
	localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
	localparam logic [1:0] REG_ACT_MODE     = 2'd2;

	// activation modes; code 3 behaves as identity
	localparam logic [1:0] ACT_IDENT = 2'd0;
	localparam logic [1:0] ACT_RELU  = 2'd1;
	localparam logic [1:0] ACT_TABLE = 2'd2;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_BIAS   = 2'd1,
		CMD_TABLE  = 2'd2,
		CMD_DATA   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         column;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] input_count;
		logic [CNT_W-1:0] output_count;
		logic [1:0]       act_mode;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] count;
	} q_stat_t;

	localparam int Q_DEPTH = 2;

endpackage

// ----- src/dlf_front.sv -----
// ---------------------------------------------------------------------------
// dlf_front: input acceptance and command queue
// Holds items, unpacked from stream transactions at the top level, in a two-entry queue.
// ---------------------------------------------------------------------------
module dlf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dlf_pkg::item_t       in_item,
	input  logic                 pop,
	output dlf_pkg::item_t       q_item,
	output dlf_pkg::q_stat_t     q_stat
);
	import dlf_pkg::*;

	item_t      entry_q [Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign in_ready = (count_q != 2'(Q_DEPTH));
	assign push     = in_valid && in_ready;
	assign do_pop   = pop && (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];
	assign q_stat   = '{valid: (count_q != 2'd0), count: count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_item;
	end

endmodule

// ----- src/dlf_back.sv -----
// ---------------------------------------------------------------------------
// dlf_back: store writes, multiply-accumulate sweep and result emission
// One shared multiplier walks the neurons of a weight row; at end of vector
// each neuron goes through bias, saturation and activation.
// ---------------------------------------------------------------------------
module dlf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dlf_pkg::cfg_t          cfg,
	input  dlf_pkg::q_stat_t       q_stat,
	input  dlf_pkg::item_t         q_item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [dlf_pkg::DATA_W-1:0] out_result,
	output logic [dlf_pkg::NEU_W-1:0]  out_neuron,
	output logic                   out_final
);
	import dlf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MAC, ST_DRAIN, ST_EMIT_RD, ST_EMIT_Z, ST_EMIT_ACT, ST_EMIT_OUT
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] weight_mem [IN_MAX*OUT_MAX];
	logic [DATA_W-1:0] bias_mem   [OUT_MAX];
	logic [DATA_W-1:0] table_mem  [TABLE_DEPTH];
	logic [ACC_W-1:0]  acc_mem    [OUT_MAX];
	logic [OUT_MAX-1:0] acc_vld_q;

	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NEU_W-1:0] emit_n_q;
	logic signed [DATA_W-1:0] x_q;
	logic last_q;

	logic [CNT_W-1:0] n_in, n_out;

	// MAC pipeline
	logic             v_s1, v_s2;
	logic [NEU_W-1:0] n_s1, n_s2;
	logic signed [DATA_W-1:0]   w_rd_q;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic [ACC_W-1:0] acc_rd_q;
	logic             acc_rd_vld_q;
	logic [NEU_W-1:0] acc_raddr;
	logic [ACC_W-1:0] acc_sum;

	// emission
	logic signed [DATA_W-1:0] bias_rd_q;
	logic signed [DATA_W-1:0] z_q;
	logic [DATA_W-1:0]        tbl_rd_q;
	logic signed [ACC_W-1:0]  acc_eff;
	logic signed [ACC_W-Q_FRAC:0] z_wide;
	logic signed [DATA_W-1:0] z_sat;
	logic signed [DATA_W-1:0] y;
	logic out_load;
	logic emit_last;

	assign n_in  = (cfg.input_count  > CNT_W'(IN_MAX))  ? CNT_W'(IN_MAX)  : cfg.input_count;
	assign n_out = (cfg.output_count > CNT_W'(OUT_MAX)) ? CNT_W'(OUT_MAX) : cfg.output_count;

	assign pop = (state_q == ST_IDLE) && q_stat.valid;

	assign acc_raddr = (state_q == ST_EMIT_RD) ? emit_n_q : n_s1;
	assign acc_sum   = (acc_rd_vld_q ? acc_rd_q : '0)
	                 + ACC_W'({{(ACC_W-2*DATA_W){prod_s2[2*DATA_W-1]}}, prod_s2});

	// arithmetic shift is floor division by 4096
	assign acc_eff = acc_rd_vld_q ? signed'(acc_rd_q) : '0;
	assign z_wide  = (ACC_W-Q_FRAC+1)'(acc_eff >>> Q_FRAC)
	               + (ACC_W-Q_FRAC+1)'(bias_rd_q);
	always_comb begin
		if (z_wide > (ACC_W-Q_FRAC+1)'(32767))       z_sat = 16'sh7fff;
		else if (z_wide < -(ACC_W-Q_FRAC+1)'(32768)) z_sat = -16'sh8000;
		else                                         z_sat = z_wide[DATA_W-1:0];
	end

	always_comb begin
		case (cfg.act_mode)
			ACT_RELU:  y = z_q[DATA_W-1] ? '0 : z_q;
			ACT_TABLE: y = tbl_rd_q;
			default:   y = z_q;
		endcase
	end

	assign out_load  = (state_q == ST_EMIT_OUT) && (!out_valid || out_ready);
	assign emit_last = (CNT_W'(emit_n_q) + CNT_W'(1)) == n_out;

	// stores
	always_ff @(posedge clk) begin
		if (pop && q_item.cmd == CMD_WEIGHT && q_item.column < COL_W'(OUT_MAX))
			weight_mem[{q_item.row, q_item.column[NEU_W-1:0]}] <= q_item.value;
		if (pop && q_item.cmd == CMD_BIAS && q_item.column < COL_W'(OUT_MAX))
			bias_mem[q_item.column[NEU_W-1:0]] <= q_item.value;
		if (pop && q_item.cmd == CMD_TABLE)
			table_mem[q_item.column] <= q_item.value;
		w_rd_q    <= weight_mem[{pos_q[ROW_W-1:0], cnt_q[NEU_W-1:0]}];
		bias_rd_q <= bias_mem[emit_n_q];
		// (Z >> 8) + 128 for a 256-entry table
		tbl_rd_q  <= table_mem[{~z_q[DATA_W-1], z_q[DATA_W-2:DATA_W-TBL_AW]}];
		acc_rd_q  <= acc_mem[acc_raddr];
		if (v_s2) acc_mem[n_s2] <= acc_sum;
		prod_s2   <= x_q * w_rd_q;
		n_s1      <= cnt_q[NEU_W-1:0];
		n_s2      <= n_s1;
		if (state_q == ST_EMIT_Z) z_q <= z_sat;
		if (out_load) begin
			out_result <= y;
			out_neuron <= emit_n_q;
			out_final  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			acc_vld_q    <= '0;
			acc_rd_vld_q <= 1'b0;
			pos_q        <= '0;
			cnt_q        <= '0;
			emit_n_q     <= '0;
			x_q          <= '0;
			last_q       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			v_s1         <= (state_q == ST_MAC);
			v_s2         <= v_s1;
			acc_rd_vld_q <= acc_vld_q[acc_raddr];
			if (v_s2) acc_vld_q[n_s2] <= 1'b1;
			out_valid    <= out_load || (out_valid && !out_ready);

			case (state_q)
				ST_IDLE: begin
					if (pop && q_item.cmd == CMD_DATA) begin
						x_q      <= q_item.value;
						last_q   <= q_item.last;
						cnt_q    <= '0;
						emit_n_q <= '0;
						if (pos_q < n_in) begin
							state_q <= ST_MAC;
						end else if (q_item.last) begin
							if (n_out == '0) begin
								acc_vld_q <= '0;
								pos_q     <= '0;
							end else begin
								state_q <= ST_EMIT_RD;
							end
						end
					end
				end
				ST_MAC: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(OUT_MAX-1)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						if (!last_q) begin
							pos_q   <= pos_q + CNT_W'(1);
							state_q <= ST_IDLE;
						end else if (n_out == '0) begin
							acc_vld_q <= '0;
							pos_q     <= '0;
							state_q   <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + CNT_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_EMIT_RD:  state_q <= ST_EMIT_Z;
				ST_EMIT_Z:   state_q <= ST_EMIT_ACT;
				ST_EMIT_ACT: state_q <= ST_EMIT_OUT;
				ST_EMIT_OUT: begin
					if (out_load) begin
						if (emit_last) begin
							acc_vld_q <= '0;
							pos_q     <= '0;
							state_q   <= ST_IDLE;
						end else begin
							emit_n_q <= emit_n_q + NEU_W'(1);
							state_q  <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/dense_layer_forward.sv -----
// ---------------------------------------------------------------------------
// dense_layer_forward: fully connected layer with activation, Q4.12
// Store writes are done as the item is popped. A data element used in the sum
// takes the pop, one pass of the shared 16x16 multiplier over 64 neurons and
// a pipe drain. End of vector: each emitted result goes through acc/bias
// read, saturate, table and output, which waits on the output handshake.
// Reset (arst_n low) clears accumulators, position and registers to defaults.
// ---------------------------------------------------------------------------
module dense_layer_forward (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // row[5:0], column[13:6], value[29:14]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // result[15:0], neuron[21:16]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import dlf_pkg::*;

	item_t   in_item, q_item;
	q_stat_t q_stat;
	cfg_t    cfg_q;
	logic    pop;
	logic [DATA_W-1:0] out_result;
	logic [NEU_W-1:0]  out_neuron;

	assign in_item = '{cmd: cmd_t'(s_axis_tuser), row: s_axis_tdata[5:0],
	                   column: s_axis_tdata[13:6], value: s_axis_tdata[29:14],
	                   last: s_axis_tlast};
	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {2'b00, out_neuron, out_result};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{input_count: CNT_W'(IN_MAX), output_count: CNT_W'(OUT_MAX),
			           act_mode: ACT_IDENT};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INPUT_COUNT:  cfg_q.input_count  <= cfg_data;
				REG_OUTPUT_COUNT: cfg_q.output_count <= cfg_data;
				REG_ACT_MODE:     cfg_q.act_mode     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	dlf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.pop      (pop),
		.q_item   (q_item),
		.q_stat   (q_stat)
	);

	dlf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_stat     (q_stat),
		.q_item     (q_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result),
		.out_neuron (out_neuron),
		.out_final  (m_axis_tlast)
	);

	// queue occupancy stays within depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= 2'(Q_DEPTH)) else $error("queue overflow");

	// a pop only happens with something queued
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.valid) else $error("pop from empty queue");

	// the final result carries the last neuron index
	a_final_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(CNT_W'(out_neuron) + CNT_W'(1) == ((cfg_q.output_count > CNT_W'(OUT_MAX))
			? CNT_W'(OUT_MAX) : cfg_q.output_count)))
		else $error("final flag on wrong neuron");

endmodule

// ----- test/dense_layer_forward_test.sv -----
// ---------------------------------------------------------------------------
// dense_layer_forward_test: self-checking bench for the dense layer
// Loads the first weight rows and the biases, writes table entries ahead of
// the vectors that look them up, streams data vectors under several register
// settings and random stalls, and checks every neuron output against a local
// fixed-point model of the layer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dense_layer_forward_test;
	import dlf_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	// weight rows loaded; element positions used stay below this
	localparam int W_ROWS = 2;

	typedef struct {
		logic signed [15:0] result;
		logic [5:0]         neuron;
		logic               final_res;
	} neuron_out_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	dense_layer_forward dut (.*);

	always #6 clk = ~clk;

	// local layer model
	logic signed [15:0] weights [IN_MAX*OUT_MAX];
	logic signed [15:0] biases [OUT_MAX];
	logic signed [15:0] act_table [TABLE_DEPTH];
	logic [39:0]        acc_sum [OUT_MAX];
	int                 elem_pos;
	logic [6:0]         n_inputs, n_outputs;
	logic [1:0]         act_sel;
	bit                 t_written [TABLE_DEPTH];

	neuron_out_t expected_outputs [$];
	int          mismatches = 0;
	int          send_idle = 0, recv_idle = 0;
	int          idle_cycles = 0;
	bit          recv_hold = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic signed [15:0] activate(input logic signed [15:0] z);
		logic [7:0] idx;
		idx = z[15:8] ^ 8'h80;
		if (act_sel == ACT_RELU) return z < 0 ? 16'sd0 : z;
		if (act_sel == ACT_TABLE) return act_table[idx];
		return z;
	endfunction

	// saturated pre-activation value of neuron n
	function automatic logic signed [15:0] z_of(input logic [39:0] acc, input int n);
		logic signed [39:0] a;
		logic signed [40:0] z;
		a = acc;
		z = (a >>> Q_FRAC) + biases[n];
		return z > 32767 ? 16'sh7fff : z < -32768 ? 16'sh8000 : z[15:0];
	endfunction

	task automatic predict_layer(input cmd_t cmd, input logic [5:0] row, input logic [7:0] col,
			input logic signed [15:0] val, input logic last);
		int lim_in, lim_out;
		logic signed [31:0] prod;
		neuron_out_t o;
		case (cmd)
			CMD_WEIGHT: if (col < OUT_MAX) weights[row*OUT_MAX+col] = val;
			CMD_BIAS: if (col < OUT_MAX) biases[col] = val;
			CMD_TABLE: begin
				act_table[col] = val;
				t_written[col] = 1;
			end
			default: begin
				lim_in = n_inputs > IN_MAX ? IN_MAX : n_inputs;
				lim_out = n_outputs > OUT_MAX ? OUT_MAX : n_outputs;
				if (elem_pos < lim_in) begin
					for (int n = 0; n < OUT_MAX; n++) begin
						prod = val * weights[elem_pos*OUT_MAX+n];
						acc_sum[n] = acc_sum[n] + 40'(prod);
					end
					elem_pos++;
				end
				if (last) begin
					for (int n = 0; n < lim_out; n++) begin
						o.result = activate(z_of(acc_sum[n], n));
						o.neuron = 6'(n);
						o.final_res = (n + 1 == lim_out);
						expected_outputs.push_back(o);
					end
					foreach (acc_sum[i]) acc_sum[i] = '0;
					elem_pos = 0;
				end
			end
		endcase
	endtask

	task automatic send_item(input cmd_t cmd, input logic [5:0] row, input logic [7:0] col,
			input logic signed [15:0] val, input logic last);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {2'b0, val, col, row};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_layer(cmd, row, col, val, last);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_INPUT_COUNT:  n_inputs = val;
			REG_OUTPUT_COUNT: n_outputs = val;
			default:          act_sel = val[1:0];
		endcase
	endtask

	// wait for drain, then the pipeline tail of an element that emits nothing
	task automatic drain();
		s_axis_tvalid <= 0;
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_layer(input logic [6:0] ni, input logic [6:0] no, input logic [1:0] am);
		drain();
		write_reg(REG_INPUT_COUNT, ni);
		write_reg(REG_OUTPUT_COUNT, no);
		write_reg(REG_ACT_MODE, am);
		cfg_valid <= 0;
	endtask

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sd0;
			3: return 16'(int'($urandom_range(8191)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_all_stores();
		for (int r = 0; r < W_ROWS; r++)
			for (int c = 0; c < OUT_MAX; c++)
				send_item(CMD_WEIGHT, 6'(r), 8'(c), rand_value(), 1'($urandom_range(1)));
		for (int c = 0; c < OUT_MAX; c++) send_item(CMD_BIAS, 0, 8'(c), rand_value(), 0);
	endtask

	task automatic send_vector(input int len);
		logic signed [15:0] vals [$];
		logic [39:0]        acc_try [OUT_MAX];
		logic signed [31:0] prod;
		logic signed [15:0] zs;
		logic [7:0]         idx;
		int                 pos, lim_in, lim_out;
		for (int i = 0; i < len; i++) vals.push_back(rand_value());
		// write the table entries this vector will look up before sending it
		if (act_sel == ACT_TABLE) begin
			lim_in = n_inputs > IN_MAX ? IN_MAX : n_inputs;
			lim_out = n_outputs > OUT_MAX ? OUT_MAX : n_outputs;
			acc_try = acc_sum;
			pos = elem_pos;
			foreach (vals[i]) begin
				if (pos < lim_in) begin
					for (int n = 0; n < OUT_MAX; n++) begin
						prod = vals[i] * weights[pos*OUT_MAX+n];
						acc_try[n] = acc_try[n] + 40'(prod);
					end
					pos++;
				end
			end
			for (int n = 0; n < lim_out; n++) begin
				zs = z_of(acc_try[n], n);
				idx = zs[15:8] ^ 8'h80;
				if (!t_written[idx]) send_item(CMD_TABLE, 0, idx, 16'($urandom), 0);
			end
		end
		for (int i = 0; i < len; i++) send_item(CMD_DATA, 0, 0, vals[i], i == len - 1);
	endtask

	task automatic test_directed();
		// out-of-range columns are dropped, last on a write is ignored
		send_item(CMD_WEIGHT, 6'h3f, 8'hff, 16'sh7fff, 1);
		send_item(CMD_BIAS, 6'h2a, 8'h80, 16'sh8000, 1);
		send_item(CMD_WEIGHT, 0, 0, 16'sh8000, 0);
		send_item(CMD_BIAS, 0, 0, 16'sh7fff, 0);
		set_layer(2, 64, ACT_IDENT);
		send_item(CMD_DATA, 6'h3f, 8'hff, 16'sh8000, 0);
		send_item(CMD_DATA, 0, 0, 16'sh7fff, 0);
		send_item(CMD_DATA, 6'h15, 8'h55, 16'sh7fff, 0); // past input_count
		send_item(CMD_DATA, 0, 0, 16'sh8000, 1);
		set_layer(1, 1, ACT_RELU);
		send_item(CMD_DATA, 0, 0, 16'sh8000, 1);
		send_item(CMD_DATA, 0, 0, 16'sh7fff, 1);
		set_layer(0, 0, ACT_TABLE); // no element used, no result
		send_item(CMD_DATA, 0, 0, 16'sh1234, 1);
		set_layer(127, 127, 2'd3);  // counts saturate, code 3 is identity
		send_vector(2);
		set_layer(64, 5, ACT_TABLE);
		send_vector(2);
	endtask

	task automatic test_random(input int s_idle, input int r_idle, input int vectors);
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int v = 0; v < vectors; v++) begin
			if (v == 0 || $urandom_range(3) == 0)
				set_layer(7'($urandom_range(W_ROWS, 1)), 7'($urandom_range(64, 1)),
				          2'($urandom_range(3)));
			if ($urandom_range(5) == 0)
				send_item(cmd_t'($urandom_range(2)), 6'($urandom), 8'($urandom), rand_value(),
				          1'($urandom));
			send_vector($urandom_range(4, 1));
		end
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		set_layer(2, 64, ACT_RELU);
		recv_hold = 1;
		fork
			begin
				repeat (2000) @(posedge clk);
				recv_hold = 0;
			end
			for (int v = 0; v < 4; v++) send_vector(2);
		join
		drain();
		send_vector(2);
	endtask

	initial begin
		n_inputs = 64;
		n_outputs = 64;
		act_sel = ACT_IDENT;
		elem_pos = 0;
		foreach (acc_sum[i]) acc_sum[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		load_all_stores();
		test_directed();
		test_random(31, 64, 10);
		test_random(64, 31, 10);
		test_random(0, 0, 10);
		test_backpressure();
		set_layer(2, 64, ACT_TABLE);
		send_vector(4);
		drain();
		if (mismatches == 0 && expected_outputs.size() == 0)
			$display("dense_layer_forward test passed");
		else
			$display("dense_layer_forward test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 0;
		else m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
	end

	// result checker
	always @(posedge clk) begin
		neuron_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_outputs.size() == 0) begin
				report_mismatch("unexpected result, neuron", m_axis_tdata[21:16], -1);
			end else begin
				want = expected_outputs.pop_front();
				if (m_axis_tdata[15:0] !== want.result)
					report_mismatch("result", $signed(m_axis_tdata[15:0]), want.result);
				if (m_axis_tdata[21:16] !== want.neuron)
					report_mismatch("neuron", m_axis_tdata[21:16], want.neuron);
				if (m_axis_tlast !== want.final_res)
					report_mismatch("final", m_axis_tlast, want.final_res);
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("dense_layer_forward test failed");
			$finish;
		end
	end

endmodule
